### sv/cdm_pkg.sv
// ----------------------------------------------------------------------------
// cdm_pkg: channel density map shared types and constants
// Operation codes, sequencer states, and the input/output word layouts.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int unsigned MAX_TRACKS = 255;
  localparam int unsigned DW  = 10;
  localparam int unsigned LW  = 24;
  localparam int unsigned CW  = 9;
  localparam logic [DW-1:0] DMAX = 10'd1023;

  typedef enum logic [2:0] {
    OP_LOAD_DENS = 3'd0,
    OP_LOAD_PIN  = 3'd1,
    OP_ADJUST    = 3'd2,
    OP_MAX_RANGE = 3'd3,
    OP_LOAD_PEAK = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_TOP    = 2'd3
  } side_e;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'd0,
    REG_COL_COUNT = 1'd1
  } reg_e;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_SCANR = 8'b00000100,
    ST_SCANC = 8'b00001000,
    ST_BUMPR = 8'b00010000,
    ST_BUMPC = 8'b00100000,
    ST_QUERY = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_e;

  // input word, highest bit first
  typedef struct packed {
    logic [CW-1:0] dst_row;
    logic [CW-1:0] dst_col;
    logic [CW-1:0] src_row;
    logic [CW-1:0] src_col;
    logic [7:0]    segment;
    logic [15:0]   net_id;
    logic [DW-1:0] value_b;
    logic [DW-1:0] value;
    logic [7:0]    hi_index;
    logic [7:0]    index;
    logic [1:0]    side;
    logic [2:0]    operation;
  } in_word_t;

  typedef struct packed {
    logic [DW-1:0] col_peak_out;
    logic [DW-1:0] row_peak_out;
    logic [DW-1:0] range_max;
    logic          reached_peak;
  } out_word_t;

endpackage

### sv/channel_density_map_core.sv
// ----------------------------------------------------------------------------
// channel_density_map_core: routing channel density bookkeeping
// Row/column density tables with peaks and side pin labels; load, adjust and
// range-max operations run one index per pass through a shared sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 word
//  s_axis    in   s_axis_tvalid/tready      tdata: command fields
//  m_axis    out  m_axis_tvalid/tready      tdata: result fields
//  cfg       in   cfg_valid_i/cfg_ready_o   index 0 row_count, 1 col_count
//
//  After reset a clearing pass over all MAX_TRACKS+1 addresses zeroes all
//  memories while s_axis_tready stays low. Loads are written on accept; a
//  query reads each index in range in turn; adjust scans the row and column
//  labels, then bumps each entry outside the pin span (read, modify, write
//  on one port). One command is worked at a time; a finished result
//  waits in the output register while the next command runs, and the
//  sequencer holds in its output state while that register is still full.
// ----------------------------------------------------------------------------
module channel_density_map_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0] side[4:3] index[12:5] hi_index[20:13] value[30:21] value_b[40:31]
  // net_id[56:41] segment[64:57] src_col[73:65] src_row[82:74]
  // dst_col[91:83] dst_row[100:92], zero pad to 104
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reached_peak[0] range_max[10:1] row_peak_out[20:11] col_peak_out[30:21]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);
  localparam int unsigned Tbl = cdm_pkg::MAX_TRACKS + 1;
  localparam int unsigned AW  = $clog2(Tbl);
  localparam int unsigned KW  = AW + 1;

  localparam int unsigned DW = cdm_pkg::DW;
  localparam int unsigned LW = cdm_pkg::LW;

  cdm_pkg::state_e   state_q, state_d;
  cdm_pkg::in_word_t cmd_q;
  logic [7:0]    row_cnt_q, col_cnt_q;
  logic [DW-1:0] row_peak_q, col_peak_q;
  logic [KW-1:0] k_q;
  logic          ph_q;         // 0 issue read, 1 read data valid
  logic          wb_q;         // bump write phase
  logic          hit_q;
  logic [DW-1:0] rmax_q;
  logic [KW-1:0] minpr_q, maxpr_q, minpc_q, maxpc_q;
  logic          out_v_q;
  cdm_pkg::out_word_t out_q;

  // effective counts, tops
  logic [KW:0] rc, cc;
  logic [KW:0] nrow, ncol;
  always_comb begin
    rc = ((KW+1)'(row_cnt_q) > (KW+1)'(Tbl)) ? (KW+1)'(Tbl) : (KW+1)'(row_cnt_q);
    cc = ((KW+1)'(col_cnt_q) > (KW+1)'(Tbl)) ? (KW+1)'(Tbl) : (KW+1)'(col_cnt_q);
    nrow = rc - (KW+1)'(1);
    ncol = cc - (KW+1)'(1);
    if (rc == '0) nrow = '0;
    if (cc == '0) ncol = '0;
  end

  // memories
  logic          rd_we, cd_we, lw_we, rw_we, bw_we, tw_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] d_wdata, rd_q, cd_q;
  logic [LW-1:0] l_wdata, lq, rq, bq, tq;

  cdm_ram #(.Width(DW), .Depth(Tbl)) u_row (.clk_i, .we_i(rd_we), .addr_i(ram_addr),
    .wdata_i(d_wdata), .rdata_o(rd_q));
  cdm_ram #(.Width(DW), .Depth(Tbl)) u_col (.clk_i, .we_i(cd_we), .addr_i(ram_addr),
    .wdata_i(d_wdata), .rdata_o(cd_q));
  cdm_ram #(.Width(LW), .Depth(Tbl)) u_lft (.clk_i, .we_i(lw_we), .addr_i(ram_addr),
    .wdata_i(l_wdata), .rdata_o(lq));
  cdm_ram #(.Width(LW), .Depth(Tbl)) u_rgt (.clk_i, .we_i(rw_we), .addr_i(ram_addr),
    .wdata_i(l_wdata), .rdata_o(rq));
  cdm_ram #(.Width(LW), .Depth(Tbl)) u_bot (.clk_i, .we_i(bw_we), .addr_i(ram_addr),
    .wdata_i(l_wdata), .rdata_o(bq));
  cdm_ram #(.Width(LW), .Depth(Tbl)) u_top (.clk_i, .we_i(tw_we), .addr_i(ram_addr),
    .wdata_i(l_wdata), .rdata_o(tq));

  cdm_pkg::in_word_t in_w;
  assign in_w = cdm_pkg::in_word_t'(s_axis_tdata[100:0]);

  logic [LW-1:0] lab;
  assign lab = {cmd_q.net_id, cmd_q.segment};

  // bump range for current table; the row range is also needed while the
  // column scan ends, to start the row bump
  logic [KW:0] ra, rb, blo, bhi, btop, pmin, pmax;
  logic [KW:0] kx;
  logic [DW-1:0] cur, inc;
  always_comb begin
    if (state_q == cdm_pkg::ST_BUMPR || state_q == cdm_pkg::ST_SCANC) begin
      ra = (KW+1)'(cmd_q.src_row); rb = (KW+1)'(cmd_q.dst_row);
      btop = nrow; pmin = (KW+1)'(minpr_q); pmax = (KW+1)'(maxpr_q);
      cur = rd_q;
    end else begin
      ra = (KW+1)'(cmd_q.src_col); rb = (KW+1)'(cmd_q.dst_col);
      btop = ncol; pmin = (KW+1)'(minpc_q); pmax = (KW+1)'(maxpc_q);
      cur = cd_q;
    end
    blo = (ra < rb) ? ra : rb;
    bhi = (ra < rb) ? rb : ra;
    if (blo < (KW+1)'(1)) blo = (KW+1)'(1);
    if (blo > btop) blo = btop;
    if (bhi < (KW+1)'(1)) bhi = (KW+1)'(1);
    if (bhi > btop) bhi = btop;
    kx = {1'b0, k_q};
    inc = (cur < cdm_pkg::DMAX) ? cur + DW'(1) : cur;
  end

  logic in_span;
  assign in_span = (kx >= pmin) && (kx <= pmax);

  // query bounds
  logic [KW:0] qtop, qhi;
  assign qtop = cmd_q.side[0] ? nrow : ncol;
  assign qhi  = ((KW+1)'(cmd_q.hi_index) > qtop) ? qtop : (KW+1)'(cmd_q.hi_index);

  assign s_axis_tready = (state_q == cdm_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q};

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // result register free or being emptied this cycle
  logic out_fire;
  assign out_fire = (state_q == cdm_pkg::ST_OUT) && (!out_v_q || m_axis_tready);

  // memory port control
  always_comb begin
    rd_we = 1'b0; cd_we = 1'b0; lw_we = 1'b0; rw_we = 1'b0; bw_we = 1'b0; tw_we = 1'b0;
    ram_addr = k_q[AW-1:0];
    d_wdata  = inc;
    l_wdata  = {in_w.net_id, in_w.segment};
    unique case (state_q)
      cdm_pkg::ST_CLEAR: begin
        d_wdata = '0; l_wdata = '0;
        rd_we = 1'b1; cd_we = 1'b1; lw_we = 1'b1; rw_we = 1'b1; bw_we = 1'b1; tw_we = 1'b1;
      end
      cdm_pkg::ST_IDLE: begin
        ram_addr = in_w.index[AW-1:0];
        d_wdata  = in_w.value;
        if (accept && (in_w.index <= 8'(cdm_pkg::MAX_TRACKS))) begin
          if (in_w.operation == cdm_pkg::OP_LOAD_DENS) begin
            cd_we = (in_w.side == cdm_pkg::SIDE_LEFT);
            rd_we = (in_w.side == cdm_pkg::SIDE_RIGHT);
          end
          if (in_w.operation == cdm_pkg::OP_LOAD_PIN) begin
            lw_we = (in_w.side == cdm_pkg::SIDE_LEFT);
            rw_we = (in_w.side == cdm_pkg::SIDE_RIGHT);
            bw_we = (in_w.side == cdm_pkg::SIDE_BOTTOM);
            tw_we = (in_w.side == cdm_pkg::SIDE_TOP);
          end
        end
      end
      cdm_pkg::ST_BUMPR: rd_we = wb_q;
      cdm_pkg::ST_BUMPC: cd_we = wb_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= 8'd255;
      col_cnt_q <= 8'd255;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cdm_pkg::REG_ROW_COUNT) row_cnt_q <= cfg_data_i;
      else col_cnt_q <= cfg_data_i;
    end
  end

  // start of the column bump range
  function automatic logic [KW-1:0] blo_c();
    logic [KW:0] a, b, lo;
    a = (KW+1)'(cmd_q.src_col);
    b = (KW+1)'(cmd_q.dst_col);
    lo = (a < b) ? a : b;
    if (lo < (KW+1)'(1)) lo = (KW+1)'(1);
    if (lo > ncol) lo = ncol;
    return lo[KW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cdm_pkg::ST_CLEAR;
      k_q        <= '0;
      ph_q       <= 1'b0;
      wb_q       <= 1'b0;
      out_v_q    <= 1'b0;
      row_peak_q <= '0;
      col_peak_q <= '0;
      hit_q      <= 1'b0;
      rmax_q     <= '0;
    end else begin
      if (out_fire) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        cdm_pkg::ST_CLEAR: begin
          if (k_q == KW'(cdm_pkg::MAX_TRACKS)) begin
            k_q <= '0;
            state_q <= cdm_pkg::ST_IDLE;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        cdm_pkg::ST_IDLE: begin
          if (accept) begin
            cmd_q  <= in_w;
            hit_q  <= 1'b0;
            rmax_q <= '0;
            ph_q   <= 1'b0;
            wb_q   <= 1'b0;
            minpr_q <= rc[KW-1:0]; maxpr_q <= '0;
            minpc_q <= cc[KW-1:0]; maxpc_q <= '0;
            k_q <= KW'(1);
            unique case (in_w.operation)
              cdm_pkg::OP_ADJUST:    state_q <= cdm_pkg::ST_SCANR;
              cdm_pkg::OP_MAX_RANGE: begin
                k_q <= (in_w.index < 8'd1) ? KW'(1) : KW'(in_w.index);
                state_q <= cdm_pkg::ST_QUERY;
              end
              cdm_pkg::OP_LOAD_PEAK: begin
                row_peak_q <= in_w.value;
                col_peak_q <= in_w.value_b;
                state_q <= cdm_pkg::ST_OUT;
              end
              default: state_q <= cdm_pkg::ST_OUT;
            endcase
          end
        end
        cdm_pkg::ST_SCANR: begin
          if ((KW+1)'(k_q) >= rc) begin
            k_q <= KW'(1); ph_q <= 1'b0;
            state_q <= cdm_pkg::ST_SCANC;
          end else if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (lq == lab || rq == lab) begin
              if (k_q < minpr_q) minpr_q <= k_q;
              if (k_q > maxpr_q) maxpr_q <= k_q;
            end
            // column forcing applied after column scan ordering is irrelevant:
            // 1 and ncol are extreme values, so apply as min/max now
            if (lq == lab) minpc_q <= KW'(1);
            if (rq == lab) maxpc_q <= ncol[KW-1:0];
            k_q <= k_q + KW'(1);
          end
        end
        cdm_pkg::ST_SCANC: begin
          if ((KW+1)'(k_q) >= cc) begin
            ph_q <= 1'b0; wb_q <= 1'b0;
            k_q <= blo[KW-1:0];
            state_q <= cdm_pkg::ST_BUMPR;
          end else if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (bq == lab || tq == lab) begin
              if (k_q < minpc_q) minpc_q <= k_q;
              if (k_q > maxpc_q) maxpc_q <= k_q;
            end
            if (bq == lab) minpr_q <= KW'(1);
            if (tq == lab) maxpr_q <= nrow[KW-1:0];
            k_q <= k_q + KW'(1);
          end
        end
        cdm_pkg::ST_BUMPR, cdm_pkg::ST_BUMPC: begin
          if (btop < (KW+1)'(1) || kx > bhi) begin
            ph_q <= 1'b0; wb_q <= 1'b0;
            if (state_q == cdm_pkg::ST_BUMPR) begin
              state_q <= cdm_pkg::ST_BUMPC;
              k_q <= blo_c();
            end else begin
              state_q <= cdm_pkg::ST_OUT;
            end
          end else if (in_span) begin
            k_q <= k_q + KW'(1);
          end else if (!ph_q && !wb_q) begin
            ph_q <= 1'b1;
          end else if (ph_q) begin
            ph_q <= 1'b0;
            wb_q <= 1'b1;
            if (state_q == cdm_pkg::ST_BUMPR) begin
              if (inc >= row_peak_q) begin hit_q <= 1'b1; row_peak_q <= inc; end
            end else begin
              if (inc >= col_peak_q) begin hit_q <= 1'b1; col_peak_q <= inc; end
            end
          end else begin
            wb_q <= 1'b0;
            k_q <= k_q + KW'(1);
          end
        end
        cdm_pkg::ST_QUERY: begin
          if (cmd_q.side[1] || kx > qhi) begin
            state_q <= cdm_pkg::ST_OUT;
          end else if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (cmd_q.side[0]) begin
              if (rd_q > rmax_q) rmax_q <= rd_q;
            end else if (cd_q > rmax_q) begin
              rmax_q <= cd_q;
            end
            k_q <= k_q + KW'(1);
          end
        end
        cdm_pkg::ST_OUT: begin
          if (out_fire) state_q <= cdm_pkg::ST_IDLE;
        end
        default: state_q <= cdm_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_q.reached_peak <= hit_q;
      out_q.range_max    <= rmax_q;
      out_q.row_peak_out <= row_peak_q;
      out_q.col_peak_out <= col_peak_q;
    end
  end
endmodule

### sv/cdm_ram.sv
// ----------------------------------------------------------------------------
// cdm_ram: generic single-port RAM
// One address per cycle, written and read together, registered read data.
// ----------------------------------------------------------------------------
module cdm_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### bench/channel_density_map_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_density_map_core_test: self-checking bench for the density map core
// Drives command words with random gaps, predicts each result word from a
// behavioral copy of the tables, labels and peaks, and compares the whole word.
// ----------------------------------------------------------------------------
module channel_density_map_core_test;

  localparam int TBL = cdm_pkg::MAX_TRACKS + 1;
  localparam int ITEMS = 1000;
  localparam longint LIMIT = 20000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [0:0]   cfg_index_i = '0;
  logic [7:0]   cfg_data_i = '0;

  channel_density_map_core uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predicted state
  logic [7:0]             rows_m, cols_m;
  logic [cdm_pkg::DW-1:0] row_dens [TBL];
  logic [cdm_pkg::DW-1:0] col_dens [TBL];
  logic [cdm_pkg::DW-1:0] row_pk, col_pk;
  logic [cdm_pkg::LW-1:0] pin_lab [4][TBL];

  cdm_pkg::in_word_t  cmd_q [$];
  cdm_pkg::out_word_t result_q [$];
  int        errors = 0, checked = 0, adjusts = 0, peak_hits = 0;
  longint    cycles = 0;
  bit        hold_off = 1'b0;
  bit        feeding = 1'b0;

  function automatic int eff(logic [7:0] c);
    return int'(c);
  endfunction

  function automatic bit bump_span(bit is_row, int a, int b, int top, int pmin, int pmax);
    int lo, hi;
    bit hit;
    hit = 0;
    if (top < 1) return 0;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    lo = lo < 1 ? 1 : (lo > top ? top : lo);
    hi = hi < 1 ? 1 : (hi > top ? top : hi);
    for (int k = lo; k <= hi; k++) begin
      if (k < pmin || k > pmax) begin
        if (is_row) begin
          if (row_dens[k] < cdm_pkg::DMAX) row_dens[k]++;
          if (row_dens[k] >= row_pk) begin
            hit = 1;
            row_pk = row_dens[k];
          end
        end else begin
          if (col_dens[k] < cdm_pkg::DMAX) col_dens[k]++;
          if (col_dens[k] >= col_pk) begin
            hit = 1;
            col_pk = col_dens[k];
          end
        end
      end
    end
    return hit;
  endfunction

  function automatic cdm_pkg::out_word_t predict_density(cdm_pkg::in_word_t c);
    cdm_pkg::out_word_t r;
    logic [cdm_pkg::LW-1:0] lab;
    int rc, cc, minr, maxr, minc, maxc, lo, hi, top;
    bit h1, h2;
    r = '0;
    lab = {c.net_id, c.segment};
    case (c.operation)
      cdm_pkg::OP_LOAD_DENS: begin
        if (c.side == cdm_pkg::SIDE_LEFT) col_dens[c.index] = c.value;
        else if (c.side == cdm_pkg::SIDE_RIGHT) row_dens[c.index] = c.value;
      end
      cdm_pkg::OP_LOAD_PIN: pin_lab[c.side][c.index] = lab;
      cdm_pkg::OP_ADJUST: begin
        rc = eff(rows_m);
        cc = eff(cols_m);
        minr = rc; maxr = 0; minc = cc; maxc = 0;
        for (int k = 1; k < rc; k++) begin
          if (pin_lab[cdm_pkg::SIDE_LEFT][k] == lab) begin
            minc = 1;
            if (k < minr) minr = k;
            if (k > maxr) maxr = k;
          end
          if (pin_lab[cdm_pkg::SIDE_RIGHT][k] == lab) begin
            maxc = cc - 1;
            if (k < minr) minr = k;
            if (k > maxr) maxr = k;
          end
        end
        for (int k = 1; k < cc; k++) begin
          if (pin_lab[cdm_pkg::SIDE_BOTTOM][k] == lab) begin
            minr = 1;
            if (k < minc) minc = k;
            if (k > maxc) maxc = k;
          end
          if (pin_lab[cdm_pkg::SIDE_TOP][k] == lab) begin
            maxr = rc - 1;
            if (k < minc) minc = k;
            if (k > maxc) maxc = k;
          end
        end
        h1 = bump_span(1, int'(c.src_row), int'(c.dst_row), rc - 1, minr, maxr);
        h2 = bump_span(0, int'(c.src_col), int'(c.dst_col), cc - 1, minc, maxc);
        r.reached_peak = h1 | h2;
      end
      cdm_pkg::OP_MAX_RANGE: begin
        if (c.side == cdm_pkg::SIDE_LEFT || c.side == cdm_pkg::SIDE_RIGHT) begin
          top = eff(c.side == cdm_pkg::SIDE_RIGHT ? rows_m : cols_m) - 1;
          lo = c.index < 1 ? 1 : int'(c.index);
          hi = int'(c.hi_index) > top ? top : int'(c.hi_index);
          for (int k = lo; k <= hi; k++) begin
            if (c.side == cdm_pkg::SIDE_RIGHT && row_dens[k] > r.range_max)
              r.range_max = row_dens[k];
            if (c.side == cdm_pkg::SIDE_LEFT && col_dens[k] > r.range_max)
              r.range_max = col_dens[k];
          end
        end
      end
      cdm_pkg::OP_LOAD_PEAK: begin
        row_pk = c.value;
        col_pk = c.value_b;
      end
      default: ;
    endcase
    r.row_peak_out = row_pk;
    r.col_peak_out = col_pk;
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      result_q.push_back(predict_density(cdm_pkg::in_word_t'(s_axis_tdata[100:0])));
      if (s_axis_tdata[2:0] == cdm_pkg::OP_ADJUST) adjusts++;
    end
    if (s_axis_tvalid && !s_axis_tready) begin
    end else if (send_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (feeding && cmd_q.size() > 0) begin
      s_axis_tdata <= {3'b000, cmd_q.pop_front()};
      s_axis_tvalid <= 1'b1;
      send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk_i) begin
    cdm_pkg::out_word_t got, want;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got = cdm_pkg::out_word_t'(m_axis_tdata[30:0]);
      checked++;
      if (got.reached_peak) peak_hits++;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp hit=%0d max=%0d rpk=%0d cpk=%0d got hit=%0d max=%0d rpk=%0d cpk=%0d",
                     want.reached_peak, want.range_max, want.row_peak_out, want.col_peak_out,
                     got.reached_peak, got.range_max, got.row_peak_out, got.col_peak_out);
        end
      end
      recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
      m_axis_tready <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("channel_density_map_core regression: fail");
      $finish;
    end
  end

  task automatic write_count(cdm_pkg::reg_e which, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (which == cdm_pkg::REG_ROW_COUNT) rows_m = val;
    else cols_m = val;
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    while (cmd_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(posedge clk_i);
    feeding = 1'b0;
    repeat (20) @(posedge clk_i);
  endtask

  function automatic cdm_pkg::in_word_t mk(cdm_pkg::op_e op, logic [1:0] sd, logic [7:0] ix,
                                           logic [7:0] hx);
    cdm_pkg::in_word_t c;
    c = '0;
    c.operation = op;
    c.side = sd;
    c.index = ix;
    c.hi_index = hx;
    return c;
  endfunction

  function automatic cdm_pkg::in_word_t rand_cmd(int nets);
    cdm_pkg::in_word_t c;
    logic [127:0] raw;
    int pick;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[100:0];
    pick = $urandom_range(0, 99);
    c.operation = pick < 20 ? cdm_pkg::OP_LOAD_DENS : pick < 45 ? cdm_pkg::OP_LOAD_PIN :
                  pick < 75 ? cdm_pkg::OP_ADJUST : pick < 92 ? cdm_pkg::OP_MAX_RANGE :
                  pick < 96 ? cdm_pkg::OP_LOAD_PEAK : 3'($urandom_range(5, 7));
    // mostly a few nets, so pin labels actually match during adjust
    if ($urandom_range(0, 9) != 0) begin
      c.net_id = 16'($urandom_range(0, nets));
      c.segment = 8'($urandom_range(0, 2));
    end
    if ($urandom_range(0, 3) != 0) begin
      c.src_col = 9'($urandom_range(0, 40)); c.dst_col = 9'($urandom_range(0, 40));
      c.src_row = 9'($urandom_range(0, 40)); c.dst_row = 9'($urandom_range(0, 40));
    end else begin
      c.src_col = 9'($urandom_range(0, 256)); c.dst_col = 9'($urandom_range(0, 256));
      c.src_row = 9'($urandom_range(0, 256)); c.dst_row = 9'($urandom_range(0, 256));
    end
    return c;
  endfunction

  initial begin
    cdm_pkg::in_word_t c;
    logic [127:0] raw;
    int hold;
    rows_m = 8'd255;
    cols_m = 8'd255;
    row_pk = '0;
    col_pk = '0;
    for (int k = 0; k < TBL; k++) begin
      row_dens[k] = '0;
      col_dens[k] = '0;
      for (int s = 0; s < 4; s++) pin_lab[s][k] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, saturation, bad sides, unknown ops, empty query
    c = mk(cdm_pkg::OP_LOAD_DENS, cdm_pkg::SIDE_RIGHT, 8'd255, 8'd0);
    c.value = cdm_pkg::DMAX; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_LOAD_DENS, cdm_pkg::SIDE_LEFT, 8'd1, 8'd0);
    c.value = cdm_pkg::DMAX; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_LOAD_DENS, cdm_pkg::SIDE_TOP, 8'd3, 8'd0);
    c.value = 10'd77; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_LOAD_PEAK, 2'd0, 8'd0, 8'd0);
    c.value = 10'd2; c.value_b = cdm_pkg::DMAX; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_ADJUST, 2'd0, 8'd0, 8'd0);
    c.src_col = 9'd256; c.src_row = 9'd256; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_LOAD_PIN, cdm_pkg::SIDE_LEFT, 8'd5, 8'd0);
    c.net_id = 16'hffff; c.segment = 8'hff;
    cmd_q.push_back(c);
    c.side = cdm_pkg::SIDE_TOP; c.index = 8'd9; cmd_q.push_back(c);
    c.side = cdm_pkg::SIDE_RIGHT; c.index = 8'd200; cmd_q.push_back(c);
    c.side = cdm_pkg::SIDE_BOTTOM; c.index = 8'd255; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_ADJUST, 2'd0, 8'd0, 8'd0); c.net_id = 16'hffff; c.segment = 8'hff;
    c.dst_col = 9'd256; c.dst_row = 9'd256; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_ADJUST, 2'd0, 8'd0, 8'd0);
    c.dst_col = 9'd30; c.dst_row = 9'd30; cmd_q.push_back(c);
    cmd_q.push_back(mk(cdm_pkg::OP_MAX_RANGE, cdm_pkg::SIDE_RIGHT, 8'd0, 8'd255));
    cmd_q.push_back(mk(cdm_pkg::OP_MAX_RANGE, cdm_pkg::SIDE_LEFT, 8'd0, 8'd255));
    cmd_q.push_back(mk(cdm_pkg::OP_MAX_RANGE, cdm_pkg::SIDE_LEFT, 8'd50, 8'd10));
    cmd_q.push_back(mk(cdm_pkg::OP_MAX_RANGE, cdm_pkg::SIDE_BOTTOM, 8'd0, 8'd255));
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[100:0]; c.operation = 3'd5; cmd_q.push_back(c);
    c.operation = 3'd7; cmd_q.push_back(c);
    c = mk(cdm_pkg::OP_LOAD_PEAK, 2'd0, 8'd0, 8'd0); cmd_q.push_back(c);
    run_phase();

    // tiny channels
    write_count(cdm_pkg::REG_ROW_COUNT, 8'd1);
    write_count(cdm_pkg::REG_COL_COUNT, 8'd0);
    for (int i = 0; i < 20; i++) cmd_q.push_back(rand_cmd(3));
    run_phase();

    // receiver holds off while commands keep coming
    write_count(cdm_pkg::REG_ROW_COUNT, 8'd40);
    write_count(cdm_pkg::REG_COL_COUNT, 8'd40);
    for (int i = 0; i < 30; i++) begin
      c = rand_cmd(3);
      if (c.operation == cdm_pkg::OP_ADJUST) c.operation = cdm_pkg::OP_LOAD_PIN;
      cmd_q.push_back(c);
    end
    hold_off = 1'b1;
    feeding = 1'b1;
    hold = 0;
    while (hold < 3000) begin
      @(posedge clk_i);
      hold++;
    end
    hold_off = 1'b0;
    run_phase();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_count(cdm_pkg::REG_ROW_COUNT, 8'd2);
          write_count(cdm_pkg::REG_COL_COUNT, 8'd255);
        end
        1: begin
          write_count(cdm_pkg::REG_ROW_COUNT, 8'd255);
          write_count(cdm_pkg::REG_COL_COUNT, 8'd2);
        end
        2: begin
          write_count(cdm_pkg::REG_ROW_COUNT, 8'($urandom_range(3, 60)));
          write_count(cdm_pkg::REG_COL_COUNT, 8'($urandom_range(3, 60)));
        end
        default: begin
          write_count(cdm_pkg::REG_ROW_COUNT, 8'd255);
          write_count(cdm_pkg::REG_COL_COUNT, 8'd255);
        end
      endcase
      for (int i = 0; i < ITEMS / 4; i++) cmd_q.push_back(rand_cmd(ph == 3 ? 65535 : 4));
      run_phase();
    end

    repeat (200) @(posedge clk_i);
    $display("covered %0d result words, %0d adjusts, %0d peak hits, counts from 0 to 255",
             checked, adjusts, peak_hits);
    if (errors == 0 && result_q.size() == 0) begin
      $display("channel_density_map_core regression: pass");
    end else begin
      $display("%0d errors, %0d results missing", errors, result_q.size());
      $display("channel_density_map_core regression: fail");
    end
    $finish;
  end
endmodule
